// ===== rtl/asvl_pkg.sv =====
`default_nettype none

package asvl_pkg;

   localparam int unsigned FIELD_WIDTH = 16;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FORCE_HEAD = 2'd1,
      CMD_DRAIN = 2'd2,
      CMD_UNUSED = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_VERTEX = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_UNUSED = 2'd3
   } result_kind_type;

   typedef struct packed {
      logic insert;
      logic force_head;
      logic drain_step;
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/asvl_cell.sv =====
`default_nettype none

module asvl_cell #(
   parameter int unsigned COORD_WIDTH = 16,
   parameter int unsigned ANGLE_WIDTH = 16
) (
   input  wire logic                   clock,
   input  wire asvl_pkg::ctl_type      ctl,
   input  wire logic                   occupied,
   input  wire logic                   shift_prev,
   input  wire logic [COORD_WIDTH-1:0] new_x,
   input  wire logic [COORD_WIDTH-1:0] new_y,
   input  wire logic [ANGLE_WIDTH-1:0] new_angle,
   input  wire logic [COORD_WIDTH-1:0] prev_x,
   input  wire logic [COORD_WIDTH-1:0] prev_y,
   input  wire logic [ANGLE_WIDTH-1:0] prev_angle,
   input  wire logic [COORD_WIDTH-1:0] next_x,
   input  wire logic [COORD_WIDTH-1:0] next_y,
   input  wire logic [ANGLE_WIDTH-1:0] next_angle,
   output logic                        shift_self,
   output logic      [COORD_WIDTH-1:0] x,
   output logic      [COORD_WIDTH-1:0] y,
   output logic      [ANGLE_WIDTH-1:0] angle
);
   import asvl_pkg::*;

   logic [COORD_WIDTH-1:0] x_ff, x_in;
   logic [COORD_WIDTH-1:0] y_ff, y_in;
   logic [ANGLE_WIDTH-1:0] angle_ff, angle_in;

   // once a cell ahead shifts, every cell behind it shifts too
   assign shift_self = shift_prev || !occupied || ctl.force_head ||
                       ($signed(angle_ff) <= $signed(new_angle));

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      angle_in = angle_ff;
      if (ctl.drain_step) begin
         x_in = next_x;
         y_in = next_y;
         angle_in = next_angle;
      end else if (ctl.insert && shift_self) begin
         if (shift_prev) begin
            x_in = prev_x;
            y_in = prev_y;
            angle_in = prev_angle;
         end else begin
            x_in = new_x;
            y_in = new_y;
            angle_in = new_angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      angle_ff <= angle_in;
   end

   assign x = x_ff;
   assign y = y_ff;
   assign angle = angle_ff;

endmodule

`default_nettype wire

// ===== rtl/asvl_chain.sv =====
`default_nettype none

module asvl_chain #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned COORD_WIDTH = 16,
   parameter int unsigned ANGLE_WIDTH = 16,
   parameter int unsigned CW = $clog2(DEPTH + 1)
) (
   input  wire logic                   clock,
   input  wire asvl_pkg::ctl_type      ctl,
   input  wire logic [CW-1:0]          count,
   input  wire logic [COORD_WIDTH-1:0] new_x,
   input  wire logic [COORD_WIDTH-1:0] new_y,
   input  wire logic [ANGLE_WIDTH-1:0] new_angle,
   output logic      [COORD_WIDTH-1:0] head_x,
   output logic      [COORD_WIDTH-1:0] head_y
);
   import asvl_pkg::*;

   logic [COORD_WIDTH-1:0] cx [DEPTH];
   logic [COORD_WIDTH-1:0] cy [DEPTH];
   logic [ANGLE_WIDTH-1:0] ca [DEPTH];
   logic [DEPTH-1:0]       shift;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int unsigned PI = (i == 0) ? 0 : i - 1;
      localparam int unsigned NI = (i == DEPTH - 1) ? i : i + 1;
      logic occ;
      logic sp;
      assign occ = CW'(i) < count;
      assign sp = (i == 0) ? 1'b0 : shift[PI];
      asvl_cell #(
         .COORD_WIDTH(COORD_WIDTH),
         .ANGLE_WIDTH(ANGLE_WIDTH)
      ) u_cell (
         .clock(clock),
         .ctl(ctl),
         .occupied(occ),
         .shift_prev(sp),
         .new_x(new_x),
         .new_y(new_y),
         .new_angle(new_angle),
         .prev_x(cx[PI]),
         .prev_y(cy[PI]),
         .prev_angle(ca[PI]),
         .next_x(cx[NI]),
         .next_y(cy[NI]),
         .next_angle(ca[NI]),
         .shift_self(shift[i]),
         .x(cx[i]),
         .y(cy[i]),
         .angle(ca[i])
      );
   end

   assign head_x = cx[0];
   assign head_y = cy[0];

endmodule

`default_nettype wire

// ===== rtl/angle_sorted_vertex_list.sv =====
// An insert, force or empty-drain result is registered at the edge that transfers
// its command; the first drained vertex follows in the next cycle.
// Inserts and forces can be taken back to back while the result side is ready;
// a drain shifts its vertices out of the cell row's head one vertex per cycle
// while the result side is ready.
// Reset (synchronous, active high) empties the list and drops any pending result.
`default_nettype none

module angle_sorted_vertex_list #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned COORD_WIDTH = 16,
   parameter int unsigned ANGLE_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_vertex_x,
   input  wire logic [15:0] req_vertex_y,
   input  wire logic [15:0] req_vertex_angle,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [15:0]      rsp_out_x,
   output logic [15:0]      rsp_out_y,
   output logic [6:0]       rsp_entry_count,
   output logic             rsp_dropped,
   output logic             rsp_last
);
   import asvl_pkg::*;

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [ANGLE_WIDTH-1:0] FORCE_ANGLE = ANGLE_WIDTH'(10) << (ANGLE_WIDTH - 5);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   result_kind_type kind_ff, kind_in;
   logic [15:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [6:0] rsp_count_ff, rsp_count_in;
   logic dropped_ff, dropped_in, last_ff, last_in;

   logic out_free, accept, full;
   command_type cmd;
   ctl_type ctl;
   logic [COORD_WIDTH-1:0] new_x, new_y, head_x, head_y;
   logic [ANGLE_WIDTH-1:0] new_angle, in_angle;
   logic [15:0] head_x16, head_y16;

   assign cmd = command_type'(req_command);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept = req_valid && req_ready;
   assign full = count_ff == CW'(DEPTH);

   if (COORD_WIDTH >= 16) begin : g_wide
      assign new_x = COORD_WIDTH'($signed(req_vertex_x));
      assign new_y = COORD_WIDTH'($signed(req_vertex_y));
      assign head_x16 = head_x[15:0];
      assign head_y16 = head_y[15:0];
   end else begin : g_narrow
      assign new_x = req_vertex_x[COORD_WIDTH-1:0];
      assign new_y = req_vertex_y[COORD_WIDTH-1:0];
      assign head_x16 = 16'($signed(head_x));
      assign head_y16 = 16'($signed(head_y));
   end

   if (ANGLE_WIDTH >= 16) begin : g_awide
      assign in_angle = ANGLE_WIDTH'($signed(req_vertex_angle));
   end else begin : g_anarrow
      assign in_angle = req_vertex_angle[ANGLE_WIDTH-1:0];
   end

   assign new_angle = (cmd == CMD_FORCE_HEAD) ? FORCE_ANGLE : in_angle;

   always_comb begin
      ctl.insert = accept && !full && ((cmd == CMD_INSERT) || (cmd == CMD_FORCE_HEAD));
      ctl.force_head = cmd == CMD_FORCE_HEAD;
      ctl.drain_step = (state_ff == ST_DRAIN) && out_free;
   end

   asvl_chain #(
      .DEPTH(DEPTH),
      .COORD_WIDTH(COORD_WIDTH),
      .ANGLE_WIDTH(ANGLE_WIDTH),
      .CW(CW)
   ) u_chain (
      .clock(clock),
      .ctl(ctl),
      .count(count_ff),
      .new_x(new_x),
      .new_y(new_y),
      .new_angle(new_angle),
      .head_x(head_x),
      .head_y(head_y)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in = kind_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      rsp_count_in = rsp_count_ff;
      dropped_in = dropped_ff;
      last_in = last_ff;
      if (ctl.drain_step) begin
         rsp_valid_in = 1'b1;
         kind_in = KIND_VERTEX;
         out_x_in = head_x16;
         out_y_in = head_y16;
         rsp_count_in = '0;
         dropped_in = 1'b0;
         last_in = count_ff == CW'(1);
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            state_in = ST_IDLE;
         end
      end else if (accept) begin
         case (cmd)
            CMD_INSERT, CMD_FORCE_HEAD: begin
               rsp_valid_in = 1'b1;
               kind_in = KIND_STATUS;
               out_x_in = '0;
               out_y_in = '0;
               dropped_in = full;
               last_in = 1'b1;
               if (!full) begin
                  count_in = count_ff + CW'(1);
               end
               rsp_count_in = 7'(full ? count_ff : count_ff + CW'(1));
            end
            CMD_DRAIN: begin
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  kind_in = KIND_EMPTY;
                  out_x_in = '0;
                  out_y_in = '0;
                  rsp_count_in = '0;
                  dropped_in = 1'b0;
                  last_in = 1'b1;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      rsp_count_ff <= rsp_count_in;
      dropped_ff <= dropped_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_x = out_x_ff;
   assign rsp_out_y = out_y_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_dropped = dropped_ff;
   assign rsp_last = last_ff;

endmodule

`default_nettype wire
